// ----- design/gif_lzw_decoder_assert.svh -----
// Assertion macros for the port-level checker file.
`ifndef GIF_LZW_DECODER_ASSERT_SVH
`define GIF_LZW_DECODER_ASSERT_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define GLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Signal carries no X or Z once out of reset.
`define GLD_ASSERT_KNOWN(lbl, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !$isunknown(sig)) else $error(msg);

`endif

// ----- design/gld_pkg.sv -----
// Shared types, constants and helpers of the GIF LZW decoder.
package gld_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int STACK_DEPTH   = 4096;
  localparam int STACK_AW      = $clog2(STACK_DEPTH);
  localparam int SDEPTH_W      = STACK_AW + 1;
  localparam int BUF_W         = 24;
  localparam int BITS_W        = 5;
  localparam int EPOCH_W       = 4;

  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_NEED    = 3'd1,
    ST_ACCEPT  = 3'd2,
    ST_END     = 3'd3,
    ST_BAD     = 3'd4,
    ST_REFUSED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_FEED,
    OP_PIXEL,
    OP_START,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } qitem_t;

  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

  // Clamp the minimum code size to 1..8.
  function automatic logic [3:0] eff_size(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (r < 4'd1) r = 4'd1;
    if (r > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// ----- design/gld_if.sv -----
// Command and result channel interfaces.
interface gld_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface gld_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic [2:0] status;
  modport source (output valid, output pixel, output status, input ready);
  modport sink (input valid, input pixel, input status, output ready);
endinterface

// ----- design/gld_front.sv -----
// Front end: accepts command words, classifies them, queues them for the back end.
module gld_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  gld_cmd_if.sink        cmd_i,
  output gld_pkg::qhead_t head_o,
  input  logic           pop_i
);
  import gld_pkg::*;

  qitem_t     fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  qitem_t     item;

  always_comb begin
    item.data = cmd_i.data_byte;
    unique case (cmd_i.command)
      CMD_FEED:  item.op = OP_FEED;
      CMD_PIXEL: item.op = OP_PIXEL;
      CMD_START: item.op = OP_START;
      default:   item.op = OP_NOP;
    endcase
  end

  assign cmd_i.ready  = (cnt_q != 2'd2);
  assign push         = cmd_i.valid && cmd_i.ready;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      unique case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- design/gld_back.sv -----
// Back end: bit buffer, code table, expansion stack and the decode sequencer.
module gld_back #(
  parameter int MaxCodeBits = gld_pkg::MAX_CODE_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [3:0]      min_size_i,
  input  gld_pkg::qhead_t head_i,
  output logic            pop_o,
  gld_res_if.source       res_o
);
  import gld_pkg::*;

  localparam int CW    = MaxCodeBits + 1;
  localparam int TAW   = MaxCodeBits;
  localparam int TS    = 1 << MaxCodeBits;
  localparam int MEM_W = EPOCH_W + TAW + 8;
  localparam logic [CW-1:0] NONE_CODE = CW'(TS + 2);
  localparam logic [CW-1:0] NC_TOP    = CW'(TS + 2);
  localparam logic [CW-1:0] TS_C      = CW'(TS);
  localparam logic [3:0]    MAX_W     = 4'(MaxCodeBits);
  localparam logic [SDEPTH_W-1:0] STK_FULL = SDEPTH_W'(STACK_DEPTH);
  localparam logic [3:0]    RST_M     = eff_size(MIN_SIZE_RESET);

  typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_POP, S_DEC, S_WALK, S_FIN} state_e;

  state_e                state_q, state_d, ret_q, ret_d;
  logic [BUF_W-1:0]      buf_q, buf_d;
  logic [BITS_W-1:0]     bits_q, bits_d;
  logic [CW-1:0]         nc_q, nc_d, limit_q, limit_d, prev_q, prev_d;
  logic [3:0]            width_q, width_d;
  logic [SDEPTH_W-1:0]   depth_q, depth_d;
  logic [EPOCH_W-1:0]    epoch_q, epoch_d;
  logic [TAW-1:0]        sweep_q, sweep_d;
  logic [CW-1:0]         code_q, code_d, slot_q, slot_d, c_q, c_d;
  logic                  first_q, first_d, kwk_q, kwk_d, bad_q, bad_d;
  logic                  out_valid_q;
  logic [7:0]            out_pix_q;
  status_e               out_st_q;

  logic [MEM_W-1:0]      tbl_mem [TS];
  logic [MEM_W-1:0]      tbl_rdata_q, tbl_wdata;
  logic                  tbl_we, tbl_re;
  logic [TAW-1:0]        tbl_waddr, tbl_raddr;
  logic [7:0]            stk_mem [STACK_DEPTH];
  logic [7:0]            stk_rdata_q, stk_wdata;
  logic                  stk_we, stk_re;
  logic [STACK_AW-1:0]   stk_waddr, stk_raddr;

  logic                  out_free, out_set, do_init, go_on, hit;
  logic [7:0]            out_pix;
  status_e               out_st;
  logic [3:0]            m, init_w;
  logic [CW-1:0]         clear_c, eoi_c, init_nc, init_lim;
  logic [CW-1:0]         code_c, nc_inc, slot_c, cnext;
  logic [BUF_W-1:0]      buf_sh;
  logic                  grow;
  logic [SDEPTH_W-1:0]   depth_m1;
  logic [TAW-1:0]        r_prefix;
  logic [7:0]            r_suffix;

  assign out_free  = !out_valid_q || res_o.ready;
  assign res_o.valid  = out_valid_q;
  assign res_o.pixel  = out_pix_q;
  assign res_o.status = out_st_q;

  assign m        = eff_size(min_size_i);
  assign clear_c  = CW'(1) << m;
  assign eoi_c    = clear_c + CW'(1);
  assign init_nc  = clear_c + CW'(2);
  assign init_w   = m + 4'd1;
  assign init_lim = CW'(1) << init_w;

  assign code_c   = CW'(buf_q & ((BUF_W'(1) << width_q) - BUF_W'(1)));
  assign buf_sh   = buf_q >> width_q;
  assign nc_inc   = (nc_q < NC_TOP) ? nc_q + CW'(1) : nc_q;
  assign grow     = (nc_inc > limit_q) && (width_q < MAX_W);
  assign slot_c   = nc_inc - CW'(2);
  assign depth_m1 = depth_q - SDEPTH_W'(1);

  assign hit      = (tbl_rdata_q[MEM_W-1 -: EPOCH_W] == epoch_q);
  assign r_prefix = tbl_rdata_q[TAW+7:8];
  assign r_suffix = tbl_rdata_q[7:0];

  always_comb begin
    state_d = state_q;  ret_d = ret_q;  buf_d = buf_q;  bits_d = bits_q;
    nc_d = nc_q;  limit_d = limit_q;  prev_d = prev_q;  width_d = width_q;
    depth_d = depth_q;  epoch_d = epoch_q;  sweep_d = sweep_q;
    code_d = code_q;  slot_d = slot_q;  c_d = c_q;
    first_d = first_q;  kwk_d = kwk_q;  bad_d = bad_q;
    pop_o = 1'b0;  out_set = 1'b0;  out_pix = 8'd0;  out_st = ST_ACCEPT;  do_init = 1'b0;
    tbl_we = 1'b0;  tbl_waddr = '0;  tbl_wdata = '0;
    tbl_re = 1'b0;  tbl_raddr = code_c[TAW-1:0];
    stk_we = 1'b0;  stk_waddr = '0;  stk_wdata = '0;
    stk_re = 1'b0;  stk_raddr = depth_m1[STACK_AW-1:0];
    go_on = 1'b0;  cnext = '0;

    unique case (state_q)
      S_SWEEP: begin
        tbl_we    = 1'b1;
        tbl_waddr = sweep_q;
        sweep_d   = sweep_q + TAW'(1);
        if (sweep_q == '1) begin
          state_d = ret_q;
          epoch_d = EPOCH_W'(1);
        end
      end
      S_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.item.op)
            OP_PIXEL: begin
              pop_o = 1'b1;
              if (depth_q != '0) begin
                depth_d = depth_m1;
                stk_re  = 1'b1;
                state_d = S_POP;
              end else begin
                state_d = S_DEC;
              end
            end
            OP_FEED: begin
              if (out_free) begin
                pop_o   = 1'b1;
                out_set = 1'b1;
                if (bits_q > BITS_W'(BUF_W - 8)) begin
                  out_st = ST_REFUSED;
                end else begin
                  buf_d  = buf_q | (BUF_W'(head_i.item.data) << bits_q);
                  bits_d = bits_q + BITS_W'(8);
                end
              end
            end
            OP_START: begin
              if (out_free) begin
                pop_o   = 1'b1;
                out_set = 1'b1;
                do_init = 1'b1;
                depth_d = '0;
                buf_d   = '0;
                bits_d  = '0;
              end
            end
            default: begin
              if (out_free) begin
                pop_o   = 1'b1;
                out_set = 1'b1;
              end
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_set = 1'b1;
          out_st  = ST_PIXEL;
          out_pix = stk_rdata_q;
          state_d = S_IDLE;
        end
      end
      S_DEC: begin
        if (out_free) begin
          if (bits_q < BITS_W'(width_q)) begin
            out_set = 1'b1;
            out_st  = ST_NEED;
            state_d = S_IDLE;
          end else begin
            buf_d   = buf_sh;
            bits_d  = bits_q - BITS_W'(width_q);
            nc_d    = nc_inc;
            if (grow) begin
              limit_d = limit_q << 1;
              width_d = width_q + 4'd1;
            end
            if (code_c == eoi_c) begin
              out_set = 1'b1;
              out_st  = ST_END;
              state_d = S_IDLE;
            end else if (code_c == clear_c) begin
              do_init = 1'b1;
            end else if (code_c < clear_c) begin
              if (prev_q != NONE_CODE && slot_c < TS_C) begin
                tbl_we    = 1'b1;
                tbl_waddr = slot_c[TAW-1:0];
                tbl_wdata = {epoch_q, prev_q[TAW-1:0], code_c[7:0]};
              end
              prev_d  = code_c;
              out_set = 1'b1;
              out_st  = ST_PIXEL;
              out_pix = code_c[7:0];
              state_d = S_IDLE;
            end else begin
              // look up the string code, then follow its prefix chain
              tbl_re  = 1'b1;
              code_d  = code_c;
              slot_d  = slot_c;
              first_d = 1'b1;
              kwk_d   = 1'b0;
              bad_d   = 1'b0;
              state_d = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        first_d = 1'b0;
        if (!hit) begin
          if (first_q && code_q == slot_q && prev_q != NONE_CODE) begin
            // KwKwK: reserve the bottom slot for the first pixel
            stk_we    = 1'b1;
            stk_waddr = depth_q[STACK_AW-1:0];
            depth_d   = depth_q + SDEPTH_W'(1);
            kwk_d     = 1'b1;
            cnext     = prev_q;
            go_on     = 1'b1;
          end else begin
            bad_d   = 1'b1;
            state_d = S_FIN;
          end
        end else if (depth_q >= STK_FULL) begin
          bad_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          stk_we    = 1'b1;
          stk_waddr = depth_q[STACK_AW-1:0];
          stk_wdata = r_suffix;
          depth_d   = depth_q + SDEPTH_W'(1);
          cnext     = CW'(r_prefix);
          go_on     = 1'b1;
        end
        if (go_on) begin
          if (cnext > clear_c) begin
            tbl_re    = 1'b1;
            tbl_raddr = cnext[TAW-1:0];
          end else begin
            c_d     = cnext;
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_set = 1'b1;
          state_d = S_IDLE;
          if (bad_q || depth_q >= STK_FULL) begin
            depth_d = '0;
            out_st  = ST_BAD;
          end else begin
            if (kwk_q) begin
              stk_we    = 1'b1;
              stk_wdata = c_q[7:0];
            end
            if (prev_q != NONE_CODE && slot_q < TS_C) begin
              tbl_we    = 1'b1;
              tbl_waddr = slot_q[TAW-1:0];
              tbl_wdata = {epoch_q, prev_q[TAW-1:0], c_q[7:0]};
            end
            prev_d  = code_q;
            out_st  = ST_PIXEL;
            out_pix = c_q[7:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (do_init) begin
      nc_d    = init_nc;
      width_d = init_w;
      limit_d = init_lim;
      prev_d  = NONE_CODE;
      if (epoch_q == '1) begin
        // out of table generations: wipe all tags first
        ret_d   = state_d;
        state_d = S_SWEEP;
        sweep_d = '0;
      end else begin
        epoch_d = epoch_q + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    slot_q  <= slot_d;
    c_q     <= c_d;
    first_q <= first_d;
    kwk_q   <= kwk_d;
    bad_q   <= bad_d;
    if (out_set) begin
      out_pix_q <= out_pix;
      out_st_q  <= out_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      ret_q       <= S_IDLE;
      sweep_q     <= '0;
      epoch_q     <= EPOCH_W'(1);
      buf_q       <= '0;
      bits_q      <= '0;
      nc_q        <= (CW'(1) << RST_M) + CW'(2);
      width_q     <= RST_M + 4'd1;
      limit_q     <= CW'(1) << (RST_M + 4'd1);
      prev_q      <= NONE_CODE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      sweep_q <= sweep_d;
      epoch_q <= epoch_d;
      buf_q   <= buf_d;
      bits_q  <= bits_d;
      nc_q    <= nc_d;
      width_q <= width_d;
      limit_q <= limit_d;
      prev_q  <= prev_d;
      depth_q <= depth_d;
      if (out_set) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

endmodule

// ----- design/gif_lzw_decoder.sv -----
// GIF LZW decoder, 12-bit variable-width codes. Each command word gives exactly one
// result word. Feed, start and unknown commands have their result registered as the
// back end takes them. A pixel request served from the expansion stack waits for a
// stack memory read. A request that decodes is taken, reads codes until one gives a
// result, walks the prefix chain of a string code through the code table (one table
// read a cycle) and finishes a string code in a final step; its string then drains
// from the stack, each pixel request done before the next is taken. After reset, and
// on every 15th table reset (clear code or start), a tag clearing pass over all
// 2^MaxCodeBits table entries runs before decoding resumes.
// A two-word queue parts command intake from decoding; the result sits in an output
// register, so a new command is taken while a result waits.
module gif_lzw_decoder #(
  parameter int MaxCodeBits = gld_pkg::MAX_CODE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  gld_cmd_if.sink    cmd_i,
  gld_res_if.source  res_o
);
  import gld_pkg::*;

  logic [3:0] min_size_q;
  qhead_t     head;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= MIN_SIZE_RESET;
    end else if (cfg_we_i) begin
      min_size_q <= cfg_data_i;
    end
  end

  gld_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .head_o (head),
    .pop_i  (pop)
  );

  gld_back #(
    .MaxCodeBits (MaxCodeBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .min_size_i (min_size_q),
    .head_i     (head),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

// ----- design/gld_checker.sv -----
// Port-level checks of the decoder and their binding to the top level.
`include "gif_lzw_decoder_assert.svh"

module gld_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] pixel_i,
  input logic [2:0] status_i
);
  import gld_pkg::*;

  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = res_valid_i && res_ready_i;

  // count words taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  `GLD_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(pixel_i) && $stable(status_i), "result word changed while stalled")
  `GLD_ASSERT(a_no_extra, res_valid_i |-> pend_q != 3'd0, "result word without a pending command")
  `GLD_ASSERT(a_status_ok, res_valid_i |-> status_i <= ST_REFUSED, "status code out of range")
  `GLD_ASSERT(a_pix_zero, res_valid_i && status_i != ST_PIXEL |-> pixel_i == 8'd0, "pixel set on a non-pixel result")
  `GLD_ASSERT_KNOWN(a_valid_known, res_valid_i, "result valid unknown")

endmodule

bind gif_lzw_decoder gld_props u_gld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .pixel_i     (res_o.pixel),
  .status_i    (res_o.status)
);

// ----- bench/gld_checker.sv -----
// Checker for the GIF LZW decoder: predicts each result word and compares it.
module gld_checker
  import gld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  gld_cmd_if         cmd,
  gld_res_if         res,
  output int         errors_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] pixel;
    status_e    status;
  } result_t;

  result_t     expected_q[$];

  logic [11:0] prefix_mem [4096];
  logic [7:0]  suffix_mem [4096];
  logic        entry_ok   [4096];
  logic [7:0]  pix_stack  [4096];
  int unsigned depth;
  int unsigned bitbuf;
  int unsigned nbits;
  int unsigned next_code;
  int unsigned width;
  int unsigned limit;
  int unsigned prev_code;
  logic [3:0]  size_reg;

  localparam int unsigned NO_PREV = 4098;

  function automatic int unsigned clamp_size();
    int unsigned m;
    m = size_reg;
    if (m < 1) m = 1;
    if (m > 8) m = 8;
    return m;
  endfunction

  function automatic void reset_table();
    int unsigned m;
    m = clamp_size();
    foreach (entry_ok[i]) entry_ok[i] = 1'b0;
    next_code = (1 << m) + 2;
    width     = m + 1;
    limit     = 1 << width;
    prev_code = NO_PREV;
  endfunction

  function automatic void new_image();
    reset_table();
    depth  = 0;
    bitbuf = 0;
    nbits  = 0;
  endfunction

  function automatic bit stack_push(int unsigned v);
    if (depth >= 4096) return 1'b0;
    pix_stack[depth] = v[7:0];
    depth++;
    return 1'b1;
  endfunction

  // Read codes until one yields a pixel or decoding has to stop.
  function automatic status_e expand_code(output logic [7:0] pix);
    int unsigned w, code, clr, eoi, slot, c, first, base, idx;
    bit direct, kwk;
    pix = 8'd0;
    while (1) begin
      w = width & 15;
      direct = 1'b0;
      kwk = 1'b0;
      if (w > MAX_CODE_BITS) w = MAX_CODE_BITS;
      if (nbits < w) return ST_NEED;
      code   = bitbuf & ((1 << w) - 1);
      bitbuf = (bitbuf >> w) & 24'hffffff;
      nbits -= w;
      if (next_code < 4098) next_code++;
      if (next_code > limit && width < MAX_CODE_BITS) begin
        limit <<= 1;
        width++;
      end
      clr  = 1 << clamp_size();
      eoi  = clr + 1;
      slot = next_code - 2;
      if (code == eoi) return ST_END;
      if (code == clr) begin
        reset_table();
        continue;
      end
      if (code < clr) begin
        first  = code;
        direct = 1'b1;
      end else begin
        base = depth;
        c = code;
        if (!entry_ok[code & 12'hfff]) begin
          if (code != slot || prev_code == NO_PREV) begin
            depth = 0;
            return ST_BAD;
          end
          kwk = 1'b1;
          void'(stack_push(0));
          c = prev_code;
        end
        while (c > clr) begin
          idx = c & 12'hfff;
          if (c >= 4096 || !entry_ok[idx] || !stack_push(suffix_mem[idx])) begin
            depth = 0;
            return ST_BAD;
          end
          c = prefix_mem[idx];
        end
        if (!stack_push(c)) begin
          depth = 0;
          return ST_BAD;
        end
        first = c & 8'hff;
        if (kwk) pix_stack[base] = first[7:0];
      end
      if (prev_code != NO_PREV && slot < 4096) begin
        prefix_mem[slot] = prev_code[11:0];
        suffix_mem[slot] = first[7:0];
        entry_ok[slot]   = 1'b1;
      end
      prev_code = code;
      if (direct) begin
        pix = code[7:0];
      end else begin
        depth--;
        pix = pix_stack[depth];
      end
      return ST_PIXEL;
    end
    return ST_NEED;
  endfunction

  function automatic result_t predict_word(logic [1:0] op, logic [7:0] data);
    result_t r;
    logic [7:0] p;
    r.pixel  = 8'd0;
    r.status = ST_ACCEPT;
    if (op == CMD_FEED) begin
      if (nbits + 8 > BUF_W) begin
        r.status = ST_REFUSED;
      end else begin
        bitbuf = (bitbuf | (int'(data) << nbits)) & 24'hffffff;
        nbits += 8;
      end
    end else if (op == CMD_PIXEL) begin
      if (depth > 0) begin
        depth--;
        r.pixel  = pix_stack[depth];
        r.status = ST_PIXEL;
      end else begin
        r.status = expand_code(p);
        r.pixel  = p;
      end
    end else if (op == CMD_START) begin
      new_image();
    end
    if (r.status != ST_PIXEL) r.pixel = 8'd0;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      errors_o = 0;
      size_reg = MIN_SIZE_RESET;
      new_image();
    end else begin
      if (cfg_we_i) size_reg = cfg_data_i;
      if (cmd.valid && cmd.ready) expected_q.push_back(predict_word(cmd.command, cmd.data_byte));
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected word pixel=%0d status=%0d", $time, res.pixel, res.status);
        end else begin
          want = expected_q.pop_front();
          if (res.status !== want.status || res.pixel !== want.pixel) begin
            errors_o++;
            $display("%0t: mismatch expected pixel=%0d status=%0d actual pixel=%0d status=%0d",
                     $time, want.pixel, want.status, res.pixel, res.status);
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top: stimulus, flow control and verdict for the GIF LZW decoder.
module tb;
  import gld_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_data = 4'd0;
  bit         quiet = 1'b0;
  bit         done = 1'b0;
  int         errors, pending;

  gld_cmd_if cmd ();
  gld_res_if res ();

  gif_lzw_decoder dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .cmd_i(cmd), .res_o(res)
  );

  gld_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .cmd(cmd), .res(res), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Encoder-side mirror of the decoder's code width, used to pack codes.
  int unsigned g_size, g_next, g_width, g_limit, g_acc, g_nacc;
  logic [7:0]  stream_q[$];
  int          words_sent;

  task automatic put_code(int unsigned code);
    g_acc  |= code << g_nacc;
    g_nacc += g_width;
    while (g_nacc >= 8) begin
      stream_q.push_back(g_acc[7:0]);
      g_acc >>= 8;
      g_nacc -= 8;
    end
    if (g_next < 4098) g_next++;
    if (g_next > g_limit && g_width < 12) begin
      g_limit <<= 1;
      g_width++;
    end
  endtask

  task automatic gen_reset();
    g_next  = (1 << g_size) + 2;
    g_width = g_size + 1;
    g_limit = 1 << g_width;
  endtask

  // Build a code stream of mostly legal codes with random content.
  task automatic build_image(int unsigned ncodes, bit lead_clear);
    int unsigned clr, slot, code, r;
    clr = 1 << g_size;
    gen_reset();
    g_acc = 0;
    g_nacc = 0;
    if (lead_clear) put_code(clr);
    for (int i = 0; i < ncodes; i++) begin
      slot = g_next - 1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        put_code(clr);
        gen_reset();
      end else if (r < 4) begin
        put_code(clr + 1);
      end else if (r < 5 && slot + 1 < 4096) begin
        put_code(slot + 1);
      end else if (r < 15 && g_next != clr + 2 && slot < 4096) begin
        put_code(slot);
      end else if (r < 55 || g_next == clr + 2 || slot <= clr + 2) begin
        put_code($urandom_range(0, clr - 1));
      end else begin
        code = $urandom_range(clr + 2, (slot > 4096 ? 4096 : slot) - 1);
        put_code(code);
      end
    end
    put_code(clr + 1);
    if (g_nacc > 0) stream_q.push_back(g_acc[7:0]);
  endtask

  task automatic send(logic [1:0] op, logic [7:0] data);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    cmd.valid     <= 1'b1;
    cmd.command   <= op;
    cmd.data_byte <= data;
    do @(posedge clk_i); while (!cmd.ready);
    words_sent++;
  endtask

  task automatic settle();
    cmd.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(logic [3:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    g_size = (v < 1) ? 1 : (v > 8) ? 8 : v;
  endtask

  // Feed the stream with pixel requests mixed in, then drain pixels.
  task automatic play_stream(int unsigned extra);
    while (stream_q.size() > 0) begin
      if ($urandom_range(0, 99) < 55) send(CMD_PIXEL, 8'($urandom));
      else send(CMD_FEED, stream_q.pop_front());
    end
    repeat (extra) send(CMD_PIXEL, 8'($urandom));
  endtask

  // Receiver: random stall bursts and one long hold-off.
  initial begin
    int cyc;
    res.ready = 1'b0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 3000) begin
        res.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      res.ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || done) idle = 0;
      else idle++;
      if (idle >= 30000) begin
        $display("** gif_lzw_decoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] sizes[6];
    int guard;
    sizes = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd5};
    cmd.valid = 1'b0;
    cmd.command = CMD_FEED;
    cmd.data_byte = 8'd0;
    words_sent = 0;
    g_size = 8;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: starved request, full buffer, unknown command, bad code, clear code.
    send(CMD_START, 8'h00);
    send(CMD_PIXEL, 8'hff);
    send(CMD_FEED, 8'hff);
    send(CMD_FEED, 8'h00);
    send(CMD_FEED, 8'haa);
    send(CMD_FEED, 8'h55);
    send(OP_NOP, 8'h12);
    repeat (3) send(CMD_PIXEL, 8'h00);
    send(CMD_START, 8'h00);
    send(CMD_FEED, 8'h05);   // code 0x105 with no entry: bad
    send(CMD_FEED, 8'h01);
    send(CMD_FEED, 8'h02);   // then clear code
    send(CMD_FEED, 8'h04);
    repeat (3) send(CMD_PIXEL, 8'h00);
    settle();

    // Random images over several code sizes, extremes included.
    for (int ph = 0; words_sent < 1500; ph++) begin
      write_size(sizes[ph % 6]);
      if (ph % 5 != 4) send(CMD_START, 8'h00);
      else gen_reset();  // keep the old table: size changes mid-image
      build_image($urandom_range(5, 60), 1'($urandom_range(0, 1)));
      if (words_sent > 1200) quiet = 1'b1;
      play_stream($urandom_range(10, 80));
      settle();
    end

    quiet = 1'b1;
    done = 1'b1;
    guard = 0;
    while (pending != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** gif_lzw_decoder: PASSED **");
    end else begin
      $display("** gif_lzw_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/gld_pkg.sv
design/gld_if.sv
design/gld_front.sv
design/gld_back.sv
design/gif_lzw_decoder.sv
design/gld_checker.sv
bench/gld_checker.sv
bench/tb.sv
